// File: hdl/cubic_bezier_eval_at_x_core_assert.svh
// ---------------------------------------------------------------------------
// Cubic Bezier evaluator assertion macros
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_EVAL_AT_X_CORE_ASSERT_SVH
`define CUBIC_BEZIER_EVAL_AT_X_CORE_ASSERT_SVH

// Same-cycle implication, ignored during reset.
`define CBZ_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("cbz assertion failed");

// Next-cycle implication, ignored during reset.
`define CBZ_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("cbz assertion failed");

// Next-cycle implication that also holds through reset.
`define CBZ_ASSERT_NXT_ALWAYS(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("cbz assertion failed");

`endif

// File: hdl/cbz_pkg.sv
// ---------------------------------------------------------------------------
// Cubic Bezier evaluator package
// Widths, step codes, state types and the controller/datapath structs.
// ---------------------------------------------------------------------------
package cbz_pkg;

  localparam int MAX_ITER    = 24;
  localparam int T_FRAC_BITS = 24;
  localparam int TW          = T_FRAC_BITS + 1;
  localparam int RND_W       = 6;
  localparam int MA_W        = 33;
  localparam int MB_W        = T_FRAC_BITS + 4;
  localparam int PROD_W      = MA_W + MB_W;
  localparam int VAL_W       = PROD_W - T_FRAC_BITS;
  localparam int DIST_W      = VAL_W + 1;
  localparam logic [TW-1:0] ONE_T = TW'(1) << T_FRAC_BITS;

  localparam logic [3:0] EV_UU   = 4'd0;
  localparam logic [3:0] EV_TT   = 4'd1;
  localparam logic [3:0] EV_U3   = 4'd2;
  localparam logic [3:0] EV_T3   = 4'd3;
  localparam logic [3:0] EV_TU2  = 4'd4;
  localparam logic [3:0] EV_T2U  = 4'd5;
  localparam logic [3:0] EV_P0   = 4'd6;
  localparam logic [3:0] EV_P1   = 4'd7;
  localparam logic [3:0] EV_P2   = 4'd8;
  localparam logic [3:0] EV_P3   = 4'd9;
  localparam logic [3:0] EV_LAST = 4'd10;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_POST, S_ROUND, S_RNDEND, S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    EK_INIT, EK_PLUS, EK_MINUS, EK_FX, EK_FY
  } eval_kind_t;

  typedef enum logic [1:0] {
    CAND_CUR, CAND_PLUS, CAND_MINUS
  } cand_t;

  typedef struct packed {
    logic signed [31:0] query_x;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] ctrl1_x;
    logic signed [31:0] ctrl1_y;
    logic signed [31:0] ctrl2_x;
    logic signed [31:0] ctrl2_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] curve_x;
    logic signed [31:0] curve_y;
    logic [24:0]        param_t;
  } out_item_t;

  typedef struct packed {
    logic       load;
    cand_t      cand;
    logic       axis_y;
    logic [3:0] step;
    logic       take_init;
    logic       take_cand;
    logic       round_end;
    logic       save_x;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic plus_ok;
    logic minus_ok;
    logic closer;
    logic rounds_done;
  } dp_sts_t;

  function automatic logic [24:0] t_to_q24(input logic [TW-1:0] t);
    logic [TW+24:0] w;
    w = (TW+25)'(t);
    if (T_FRAC_BITS >= 24) begin
      return 25'(w >> (T_FRAC_BITS - 24));
    end
    return 25'(w << (24 - T_FRAC_BITS));
  endfunction

endpackage

// File: hdl/cbz_in_if.sv
// ---------------------------------------------------------------------------
// Cubic Bezier evaluator input channel
// Valid/ready channel carrying one query and four control points.
// ---------------------------------------------------------------------------
interface cbz_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] query_x;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] ctrl1_x;
  logic signed [31:0] ctrl1_y;
  logic signed [31:0] ctrl2_x;
  logic signed [31:0] ctrl2_y;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;

  modport source (output valid, query_x, start_x, start_y, ctrl1_x, ctrl1_y,
                  ctrl2_x, ctrl2_y, end_x, end_y, input ready);
  modport sink (input valid, query_x, start_x, start_y, ctrl1_x, ctrl1_y,
                ctrl2_x, ctrl2_y, end_x, end_y, output ready);
endinterface

// File: hdl/cbz_out_if.sv
// ---------------------------------------------------------------------------
// Cubic Bezier evaluator result channel
// Valid/ready channel carrying the curve point and the found parameter.
// ---------------------------------------------------------------------------
interface cbz_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] curve_x;
  logic signed [31:0] curve_y;
  logic [24:0]        param_t;

  modport source (output valid, curve_x, curve_y, param_t, input ready);
  modport sink (input valid, curve_x, curve_y, param_t, output ready);
endinterface

// File: hdl/cbz_datapath.sv
// ---------------------------------------------------------------------------
// Cubic Bezier evaluator datapath
// Operand registers, one shared multiplier, accumulator and search state.
// ---------------------------------------------------------------------------
module cbz_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  cbz_pkg::dp_cmd_t   cmd,
  input  cbz_pkg::in_item_t  in_item,
  output cbz_pkg::dp_sts_t   sts,
  output cbz_pkg::out_item_t out_item
);

  logic signed [31:0] q_r, p0x_r, p1x_r, p2x_r, p3x_r, p0y_r, p1y_r, p2y_r, p3y_r;
  logic [cbz_pkg::RND_W-1:0] rounds_r, rnd_r, rounds_nxt;
  logic [cbz_pkg::TW-1:0] t_r, step_r;
  logic [cbz_pkg::TW-1:0] u2_r, u3_r, t2_r, t3_r, tu2_r, t2u_r;
  logic signed [cbz_pkg::PROD_W-1:0] prod_r, acc_r;
  logic [cbz_pkg::DIST_W-1:0] dcur_r;
  logic signed [31:0] res_x_r;
  cbz_pkg::out_item_t out_r;

  logic signed [32:0] span_d;
  logic signed [36:0] span;
  logic [cbz_pkg::TW:0] t_plus, t_cand;
  logic [cbz_pkg::TW-1:0] tc, uc, wb;
  logic signed [31:0] p0, p1, p2, p3;
  logic signed [cbz_pkg::MA_W-1:0] ma;
  logic signed [cbz_pkg::MB_W-1:0] mb;
  logic signed [cbz_pkg::VAL_W-1:0] val;
  logic signed [cbz_pkg::DIST_W-1:0] diff;
  logic [cbz_pkg::DIST_W-1:0] gap_abs;
  logic signed [31:0] val_sat;

  always_comb begin
    span_d = 33'(in_item.end_x) - 33'(in_item.start_x);
    span   = (37'(span_d) <<< 3) + (37'(span_d) <<< 1);
    if (span < 0) begin
      rounds_nxt = '0;
    end else if (span[36:16] > 21'(cbz_pkg::MAX_ITER)) begin
      rounds_nxt = cbz_pkg::RND_W'(cbz_pkg::MAX_ITER);
    end else begin
      rounds_nxt = span[16+cbz_pkg::RND_W-1:16];
    end
  end

  always_comb begin
    t_plus = {1'b0, t_r} + {1'b0, step_r};
    unique case (cmd.cand)
      cbz_pkg::CAND_PLUS:  t_cand = t_plus;
      cbz_pkg::CAND_MINUS: t_cand = {1'b0, t_r} - {1'b0, step_r};
      default:             t_cand = {1'b0, t_r};
    endcase
    tc = t_cand[cbz_pkg::TW-1:0];
    uc = cbz_pkg::ONE_T - tc;
    p0 = cmd.axis_y ? p0y_r : p0x_r;
    p1 = cmd.axis_y ? p1y_r : p1x_r;
    p2 = cmd.axis_y ? p2y_r : p2x_r;
    p3 = cmd.axis_y ? p3y_r : p3x_r;
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.step)
      cbz_pkg::EV_UU:  begin ma = cbz_pkg::MA_W'(uc);    mb = cbz_pkg::MB_W'(uc); end
      cbz_pkg::EV_TT:  begin ma = cbz_pkg::MA_W'(tc);    mb = cbz_pkg::MB_W'(tc); end
      cbz_pkg::EV_U3:  begin ma = cbz_pkg::MA_W'(u2_r);  mb = cbz_pkg::MB_W'(uc); end
      cbz_pkg::EV_T3:  begin ma = cbz_pkg::MA_W'(t2_r);  mb = cbz_pkg::MB_W'(tc); end
      cbz_pkg::EV_TU2: begin ma = cbz_pkg::MA_W'(tc);    mb = cbz_pkg::MB_W'(u2_r); end
      cbz_pkg::EV_T2U: begin ma = cbz_pkg::MA_W'(t2_r);  mb = cbz_pkg::MB_W'(uc); end
      cbz_pkg::EV_P0:  begin ma = cbz_pkg::MA_W'(p0);    mb = cbz_pkg::MB_W'(u3_r); end
      cbz_pkg::EV_P1: begin
        ma = cbz_pkg::MA_W'(p1);
        mb = (cbz_pkg::MB_W'(tu2_r) << 1) + cbz_pkg::MB_W'(tu2_r);
      end
      cbz_pkg::EV_P2: begin
        ma = cbz_pkg::MA_W'(p2);
        mb = (cbz_pkg::MB_W'(t2u_r) << 1) + cbz_pkg::MB_W'(t2u_r);
      end
      cbz_pkg::EV_P3:  begin ma = cbz_pkg::MA_W'(p3);    mb = cbz_pkg::MB_W'(t3_r); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    wb      = prod_r[cbz_pkg::T_FRAC_BITS +: cbz_pkg::TW];
    val     = acc_r[cbz_pkg::PROD_W-1:cbz_pkg::T_FRAC_BITS];
    diff    = cbz_pkg::DIST_W'(val) - cbz_pkg::DIST_W'(q_r);
    gap_abs = diff[cbz_pkg::DIST_W-1] ? cbz_pkg::DIST_W'(-diff) : cbz_pkg::DIST_W'(diff);
    if (val > cbz_pkg::VAL_W'(32'sh7fffffff)) begin
      val_sat = 32'sh7fffffff;
    end else if (val < -(cbz_pkg::VAL_W'(33'sh080000000))) begin
      val_sat = 32'sh80000000;
    end else begin
      val_sat = val[31:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    unique case (cmd.step)
      cbz_pkg::EV_TT:  u2_r  <= wb;
      cbz_pkg::EV_U3:  t2_r  <= wb;
      cbz_pkg::EV_T3:  u3_r  <= wb;
      cbz_pkg::EV_TU2: t3_r  <= wb;
      cbz_pkg::EV_T2U: tu2_r <= wb;
      cbz_pkg::EV_P0:  t2u_r <= wb;
      cbz_pkg::EV_P1:  acc_r <= prod_r;
      cbz_pkg::EV_P2, cbz_pkg::EV_P3, cbz_pkg::EV_LAST: acc_r <= acc_r + prod_r;
      default: ;
    endcase
    if (cmd.load) begin
      q_r   <= in_item.query_x;
      p0x_r <= in_item.start_x;
      p1x_r <= in_item.ctrl1_x;
      p2x_r <= in_item.ctrl2_x;
      p3x_r <= in_item.end_x;
      p0y_r <= in_item.start_y;
      p1y_r <= in_item.ctrl1_y;
      p2y_r <= in_item.ctrl2_y;
      p3y_r <= in_item.end_y;
    end
    if (cmd.take_init || cmd.take_cand) begin
      dcur_r <= gap_abs;
    end
    if (cmd.save_x) begin
      res_x_r <= val_sat;
    end
    if (cmd.out_load) begin
      out_r.curve_x <= res_x_r;
      out_r.curve_y <= val_sat;
      out_r.param_t <= cbz_pkg::t_to_q24(t_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r      <= '0;
      step_r   <= cbz_pkg::ONE_T;
      rnd_r    <= '0;
      rounds_r <= '0;
    end else if (cmd.load) begin
      t_r      <= '0;
      step_r   <= cbz_pkg::ONE_T;
      rnd_r    <= '0;
      rounds_r <= rounds_nxt;
    end else begin
      if (cmd.take_cand) begin
        t_r <= tc;
      end
      if (cmd.round_end) begin
        step_r <= step_r >> 1;
        rnd_r  <= rnd_r + 1'b1;
      end
    end
  end

  assign sts.plus_ok     = (t_plus <= {1'b0, cbz_pkg::ONE_T});
  assign sts.minus_ok    = (t_r >= step_r);
  assign sts.closer      = (gap_abs < dcur_r);
  assign sts.rounds_done = (rnd_r >= rounds_r);
  assign out_item        = out_r;

endmodule

// File: hdl/cbz_ctrl.sv
// ---------------------------------------------------------------------------
// Cubic Bezier evaluator controller
// Sequences the evaluations of each search round and the final point.
// ---------------------------------------------------------------------------
module cbz_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  cbz_pkg::dp_sts_t sts,
  output cbz_pkg::dp_cmd_t cmd
);

  cbz_pkg::state_t     state_r, state_nxt;
  cbz_pkg::eval_kind_t kind_r, kind_nxt;
  logic [3:0]          step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbz_pkg::S_IDLE;
      kind_r      <= cbz_pkg::EK_INIT;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    step_nxt   = step_r;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.step   = 4'hf;
    cmd.axis_y = (kind_r == cbz_pkg::EK_FY);
    unique case (kind_r)
      cbz_pkg::EK_PLUS:  cmd.cand = cbz_pkg::CAND_PLUS;
      cbz_pkg::EK_MINUS: cmd.cand = cbz_pkg::CAND_MINUS;
      default:           cmd.cand = cbz_pkg::CAND_CUR;
    endcase

    unique case (state_r)
      cbz_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          kind_nxt  = cbz_pkg::EK_INIT;
          step_nxt  = '0;
          state_nxt = cbz_pkg::S_EVAL;
        end
      end
      cbz_pkg::S_EVAL: begin
        cmd.step = step_r;
        if (step_r == cbz_pkg::EV_LAST) begin
          state_nxt = cbz_pkg::S_POST;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      cbz_pkg::S_POST: begin
        step_nxt = '0;
        unique case (kind_r)
          cbz_pkg::EK_INIT: begin
            cmd.take_init = 1'b1;
            state_nxt     = cbz_pkg::S_ROUND;
          end
          cbz_pkg::EK_PLUS: begin
            if (sts.closer) begin
              cmd.take_cand = 1'b1;
              state_nxt     = cbz_pkg::S_RNDEND;
            end else if (sts.minus_ok) begin
              kind_nxt  = cbz_pkg::EK_MINUS;
              state_nxt = cbz_pkg::S_EVAL;
            end else begin
              state_nxt = cbz_pkg::S_RNDEND;
            end
          end
          cbz_pkg::EK_MINUS: begin
            cmd.take_cand = sts.closer;
            state_nxt     = cbz_pkg::S_RNDEND;
          end
          cbz_pkg::EK_FX: begin
            cmd.save_x = 1'b1;
            kind_nxt   = cbz_pkg::EK_FY;
            state_nxt  = cbz_pkg::S_EVAL;
          end
          default: begin
            state_nxt = cbz_pkg::S_FINISH;
          end
        endcase
      end
      cbz_pkg::S_ROUND: begin
        step_nxt  = '0;
        state_nxt = cbz_pkg::S_EVAL;
        priority if (sts.rounds_done) begin
          kind_nxt = cbz_pkg::EK_FX;
        end else if (sts.plus_ok) begin
          kind_nxt = cbz_pkg::EK_PLUS;
        end else if (sts.minus_ok) begin
          kind_nxt = cbz_pkg::EK_MINUS;
        end else begin
          state_nxt = cbz_pkg::S_RNDEND;
        end
      end
      cbz_pkg::S_RNDEND: begin
        cmd.round_end = 1'b1;
        state_nxt     = cbz_pkg::S_ROUND;
      end
      cbz_pkg::S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = cbz_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cbz_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hdl/cubic_bezier_eval_at_x_core.sv
// ---------------------------------------------------------------------------
// Cubic Bezier evaluator at a given x
// Halving search for t on the x curve, then output of (x, y) and t.
// ---------------------------------------------------------------------------
// One request at a time; each evaluation runs EV_UU to EV_LAST, then compares in S_POST.
// A search round tries t + step, t - step, both or neither; at most 24 rounds are run.
// The result loads as the controller goes idle; the next request can then be taken.
// Synchronous active-low reset clears the controller and the output valid flag.
module cubic_bezier_eval_at_x_core (
  input logic      clk,
  input logic      rst_n,
  cbz_in_if.sink   in_chan,
  cbz_out_if.source out_chan
);

  cbz_pkg::dp_cmd_t   cmd;
  cbz_pkg::dp_sts_t   sts;
  cbz_pkg::in_item_t  in_item;
  cbz_pkg::out_item_t out_item;

  assign in_item.query_x = in_chan.query_x;
  assign in_item.start_x = in_chan.start_x;
  assign in_item.start_y = in_chan.start_y;
  assign in_item.ctrl1_x = in_chan.ctrl1_x;
  assign in_item.ctrl1_y = in_chan.ctrl1_y;
  assign in_item.ctrl2_x = in_chan.ctrl2_x;
  assign in_item.ctrl2_y = in_chan.ctrl2_y;
  assign in_item.end_x   = in_chan.end_x;
  assign in_item.end_y   = in_chan.end_y;

  cbz_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cbz_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .sts      (sts),
    .out_item (out_item)
  );

  assign out_chan.curve_x = out_item.curve_x;
  assign out_chan.curve_y = out_item.curve_y;
  assign out_chan.param_t = out_item.param_t;

endmodule

// File: hdl/cbz_checker.sv
// ---------------------------------------------------------------------------
// Cubic Bezier evaluator port checker
// Watches the channel ports of the top level over time.
// ---------------------------------------------------------------------------
`include "cubic_bezier_eval_at_x_core_assert.svh"

module cbz_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [24:0] param_t
);

  `CBZ_ASSERT_NXT_ALWAYS(a_reset_clears_out, clk, !rst_n, !out_valid)
  `CBZ_ASSERT_NXT(a_out_held, clk, rst_n, out_valid && !out_ready, out_valid)
  `CBZ_ASSERT_IMP(a_t_range, clk, rst_n, out_valid, param_t <= 25'h1000000)
  `CBZ_ASSERT_NXT(a_busy_after_request, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind cubic_bezier_eval_at_x_core cbz_checker u_cbz_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .param_t   (out_chan.param_t)
);

// File: verif/tb_if.sv
// ---------------------------------------------------------------------------
// Cubic Bezier evaluator testbench channels
// The block's own interfaces are used directly; this file keeps the
// testbench layout of package, interfaces and top in separate files.
// ---------------------------------------------------------------------------
package tb_pkg;
  localparam int IDLE_TAIL = 800;
  localparam int WATCHDOG_LIMIT = 20000;
endpackage

// File: verif/tb.sv
// ---------------------------------------------------------------------------
// Cubic Bezier evaluator testbench
// Drives directed and random queries through the input channel,
// predicts each curve point and parameter with an independent halving
// search, and compares every result field by field under random idling.
// ---------------------------------------------------------------------------
module tb;

  logic clk;
  logic rst_n;
  cbz_in_if  in_chan ();
  cbz_out_if out_chan ();

  cubic_bezier_eval_at_x_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  cbz_pkg::in_item_t  pending_reqs[$];
  cbz_pkg::out_item_t expected_pts[$];
  int        fail_count;
  int        quiet_cycles;
  bit        stim_done;
  int        burst_left;
  int        gap_left;
  int        hold_left;
  int        hold_started;
  int        stall_pattern;
  int        stall_phase;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic longint floor_div_t(input longint v);
    longint m;
    if (v >= 0) begin
      return v >>> cbz_pkg::T_FRAC_BITS;
    end
    m = -v;
    return -((m + (64'sd1 <<< cbz_pkg::T_FRAC_BITS) - 1) >>> cbz_pkg::T_FRAC_BITS);
  endfunction

  function automatic longint curve_at(input longint p0, input longint p1,
                                      input longint p2, input longint p3,
                                      input longint t);
    longint u, u2, u3, t2, t3, w1, w2;
    u  = (64'sd1 <<< cbz_pkg::T_FRAC_BITS) - t;
    u2 = (u * u) >>> cbz_pkg::T_FRAC_BITS;
    u3 = (u2 * u) >>> cbz_pkg::T_FRAC_BITS;
    t2 = (t * t) >>> cbz_pkg::T_FRAC_BITS;
    t3 = (t2 * t) >>> cbz_pkg::T_FRAC_BITS;
    w1 = 3 * ((t * u2) >>> cbz_pkg::T_FRAC_BITS);
    w2 = 3 * ((t2 * u) >>> cbz_pkg::T_FRAC_BITS);
    return floor_div_t(p0 * u3 + p1 * w1 + p2 * w2 + p3 * t3);
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic longint gap_to(input longint a, input longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic cbz_pkg::out_item_t solve_point(input cbz_pkg::in_item_t r);
    cbz_pkg::out_item_t o;
    longint sx, c1, c2, ex, q, span, rounds, t, stp, one, dn;
    bit moved;
    q = r.query_x; sx = r.start_x; c1 = r.ctrl1_x; c2 = r.ctrl2_x; ex = r.end_x;
    one = 64'sd1 <<< cbz_pkg::T_FRAC_BITS;
    span = (ex - sx) * 10;
    rounds = (span >= 0) ? (span >>> 16) : 0;
    if (rounds > cbz_pkg::MAX_ITER) begin
      rounds = cbz_pkg::MAX_ITER;
    end
    t = 0;
    stp = one;
    for (longint i = 0; i < rounds; i++) begin
      dn = gap_to(curve_at(sx, c1, c2, ex, t), q);
      moved = 1'b0;
      if (t + stp <= one) begin
        if (gap_to(curve_at(sx, c1, c2, ex, t + stp), q) < dn) begin
          t = t + stp;
          moved = 1'b1;
        end
      end
      if (!moved && t >= stp) begin
        if (gap_to(curve_at(sx, c1, c2, ex, t - stp), q) < dn) begin
          t = t - stp;
        end
      end
      stp = stp >>> 1;
    end
    o.curve_x = clamp32(curve_at(sx, c1, c2, ex, t));
    o.curve_y = clamp32(curve_at(r.start_y, r.ctrl1_y, r.ctrl2_y, r.end_y, t));
    o.param_t = (cbz_pkg::T_FRAC_BITS >= 24) ? 25'(t >>> (cbz_pkg::T_FRAC_BITS - 24))
                                             : 25'(t <<< (24 - cbz_pkg::T_FRAC_BITS));
    return o;
  endfunction

  function automatic logic [31:0] rand_word(input int mode);
    case (mode)
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($urandom_range(0, 20 << 16)) - 32'(10 << 16);
      3: return 32'($urandom_range(0, 400 << 16)) - 32'(200 << 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic cbz_pkg::in_item_t make_request(input bit shaped);
    cbz_pkg::in_item_t r;
    int wm;
    wm = shaped ? (($urandom_range(0, 9) < 7) ? 2 : 3) : $urandom_range(0, 6);
    r.start_x = rand_word(wm);
    r.end_x   = r.start_x + 32'($urandom_range(0, 5 << 16));
    if (!shaped) begin
      r.end_x = rand_word(wm);
    end
    r.ctrl1_x = rand_word(wm);
    r.ctrl2_x = rand_word(wm);
    r.start_y = rand_word(wm);
    r.ctrl1_y = rand_word(wm);
    r.ctrl2_y = rand_word(wm);
    r.end_y   = rand_word(wm);
    r.query_x = shaped ? r.start_x + 32'($urandom_range(0, 5 << 16)) : rand_word(wm);
    return r;
  endfunction

  initial begin
    cbz_pkg::in_item_t r;
    logic [31:0] ext[4];
    ext[0] = 32'h7fffffff; ext[1] = 32'h80000000; ext[2] = 32'h0; ext[3] = 32'hffffffff;
    for (int k = 0; k < 4; k++) begin
      r = '{default: ext[k]};
      pending_reqs.push_back(r);
    end
    r = '{query_x: 32'sh0000_8000, start_x: 0, start_y: 0, ctrl1_x: 32'sh0000_4000,
          ctrl1_y: 32'sh0001_0000, ctrl2_x: 32'sh0000_c000, ctrl2_y: 32'sh0001_0000,
          end_x: 32'sh0001_0000, end_y: 0};
    pending_reqs.push_back(r);
    r.end_x = 32'sh0000_1999;
    pending_reqs.push_back(r);
    r.end_x = 32'sh0000_199a;
    pending_reqs.push_back(r);
    r.end_x = 32'sh0000_0000;
    pending_reqs.push_back(r);
    r.end_x = -32'sh0001_0000;
    pending_reqs.push_back(r);
    r = '{query_x: 32'sh7fff_ffff, start_x: 32'sh8000_0000, start_y: 32'sh7fff_ffff,
          ctrl1_x: 32'sh7fff_ffff, ctrl1_y: 32'sh7fff_ffff, ctrl2_x: 32'sh7fff_ffff,
          ctrl2_y: 32'sh7fff_ffff, end_x: 32'sh7fff_ffff, end_y: 32'sh7fff_ffff};
    pending_reqs.push_back(r);
    r.start_y = 32'sh8000_0000; r.ctrl1_y = 32'sh8000_0000;
    r.ctrl2_y = 32'sh8000_0000; r.end_y = 32'sh8000_0000; r.query_x = 32'sh8000_0000;
    pending_reqs.push_back(r);
    r = '{query_x: 32'sh0005_0000, start_x: 0, start_y: 0, ctrl1_x: 32'sh0001_0000,
          ctrl1_y: 0, ctrl2_x: 32'sh0002_0000, ctrl2_y: 0, end_x: 32'sh0003_0000,
          end_y: 32'sh0003_0000};
    pending_reqs.push_back(r);
    r.query_x = -32'sh0005_0000;
    pending_reqs.push_back(r);
    r.query_x = 32'sh0001_8000;
    pending_reqs.push_back(r);
    for (int k = 0; k < 650; k++) begin
      pending_reqs.push_back(make_request($urandom_range(0, 9) < 8));
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        expected_pts.push_back(solve_point(cbz_pkg::in_item_t'({in_chan.query_x,
          in_chan.start_x, in_chan.start_y, in_chan.ctrl1_x, in_chan.ctrl1_y,
          in_chan.ctrl2_x, in_chan.ctrl2_y, in_chan.end_x, in_chan.end_y})));
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_chan.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cbz_pkg::in_item_t r;
          r = pending_reqs.pop_front();
          in_chan.valid <= 1'b1;
          {in_chan.query_x, in_chan.start_x, in_chan.start_y, in_chan.ctrl1_x,
           in_chan.ctrl1_y, in_chan.ctrl2_x, in_chan.ctrl2_y, in_chan.end_x,
           in_chan.end_y} <= r;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 600);
          end
        end else begin
          in_chan.valid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      hold_left <= 0;
      hold_started <= 0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_chan.ready <= 1'b0;
      end else if (hold_started < 2 && expected_pts.size() > 0) begin
        hold_started <= hold_started + 1;
        hold_left <= 5000;
        out_chan.ready <= 1'b0;
      end else begin
        case (stall_pattern)
          0: out_chan.ready <= 1'b1;
          1: out_chan.ready <= stall_phase[1];
          2: out_chan.ready <= ($urandom_range(0, 3) != 0);
          default: out_chan.ready <= (stall_phase % 700 > 500);
        endcase
        if (stall_phase % 3000 == 0) begin
          stall_pattern <= $urandom_range(0, 3);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_pts.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h t=%h", $time, out_chan.curve_x,
                 out_chan.curve_y, out_chan.param_t);
        fail_count <= fail_count + 1;
      end else begin
        cbz_pkg::out_item_t e;
        e = expected_pts.pop_front();
        if (e.curve_x !== out_chan.curve_x || e.curve_y !== out_chan.curve_y ||
            e.param_t !== out_chan.param_t) begin
          $display("%0t: mismatch expected x=%h y=%h t=%h actual x=%h y=%h t=%h",
                   $time, e.curve_x, e.curve_y, e.param_t, out_chan.curve_x,
                   out_chan.curve_y, out_chan.param_t);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    fail_count = 0;
    stim_done = 1'b0;
    stall_pattern = 0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    {in_chan.query_x, in_chan.start_x, in_chan.start_y, in_chan.ctrl1_x, in_chan.ctrl1_y,
     in_chan.ctrl2_x, in_chan.ctrl2_y, in_chan.end_x, in_chan.end_y} = '0;
    out_chan.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (!(stim_done && expected_pts.size() == 0) &&
           quiet_cycles < tb_pkg::WATCHDOG_LIMIT) begin
      @(posedge clk);
    end
    if (quiet_cycles >= tb_pkg::WATCHDOG_LIMIT) begin
      $display("Verification failed");
    end else begin
      repeat (tb_pkg::IDLE_TAIL) @(posedge clk);
      if (fail_count == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
    end
    $finish;
  end
endmodule
